/* hdl/apfc_pkg.sv */
// ----------------------------------------------------------------------------
// apfc_pkg
// Shared types, constants and helper functions of the audio packet framer.
// ----------------------------------------------------------------------------
package apfc_pkg;

   // Frame geometry
   localparam int PAYLOAD_BYTES = 160;
   localparam int CHUNK_BYTES   = 62;
   localparam int HEADER_BYTES  = 14;

   localparam int POS_W  = 11;
   localparam int CP_W   = 8;
   localparam int HIDX_W = 4;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int PAYLOAD_WORDS = (PAYLOAD_BYTES + 1) / 2;
   localparam bit PAYLOAD_ODD   = (PAYLOAD_BYTES % 2) == 1;

   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(PAYLOAD_BYTES - 1);
   localparam logic [CP_W-1:0]   LAST_CP   = CP_W'(CHUNK_BYTES - 1);
   localparam logic [HIDX_W-1:0] LAST_HIDX = HIDX_W'(HEADER_BYTES - 1);

   // Header and stream constants
   localparam logic [31:0] SYNC_WORD   = 32'hE4E5_AB2D;
   localparam logic [15:0] MSG_ID      = 16'h2000;
   localparam logic [1:0]  PROTO_BITS  = 2'b01;
   localparam logic [15:0] CHECK_INIT  = 16'hAAAA;
   localparam logic [7:0]  MARK_LO     = 8'h31;
   localparam logic [7:0]  MARK_HI     = 8'h60;

   // Header word positions
   localparam logic [2:0] HW_SYNC_LO = 3'd0;
   localparam logic [2:0] HW_SYNC_HI = 3'd1;
   localparam logic [2:0] HW_LENGTH  = 3'd2;
   localparam logic [2:0] HW_SEQ_LO  = 3'd3;
   localparam logic [2:0] HW_SEQ_HI  = 3'd4;
   localparam logic [2:0] HW_MSG_ID  = 3'd5;
   localparam logic [2:0] HW_FLAGS   = 3'd6;

   // Register indexes
   localparam logic [1:0] REG_CONTROLLER_INDEX = 2'd0;
   localparam logic [1:0] REG_TIMESLOT_INDEX   = 2'd1;
   localparam logic [1:0] REG_DEVICE_CODE      = 2'd2;

   typedef struct packed {
      logic       controller_index;
      logic       timeslot_index;
      logic [7:0] device_code;
   } cfg_type;

   // One classified payload byte in flight between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       first;
      logic       last;
      logic       odd;
   } item_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_PAY,
      PH_PAD,
      PH_CSLO,
      PH_CSHI,
      PH_TRAIL
   } phase_type;

   typedef enum logic [1:0] {
      MK_NONE,
      MK_LO,
      MK_BOTH
   } mark_type;

   function automatic logic [15:0] mix_word(input logic [15:0] cs, input logic [15:0] w);
      logic [15:0] x;
      x = cs ^ w;
      return {x[14:0], x[15]};
   endfunction

   function automatic logic [15:0] flags_word(input cfg_type cfg);
      return {PROTO_BITS, cfg.controller_index, cfg.timeslot_index,
              cfg.device_code[3:0], cfg.device_code};
   endfunction

   function automatic logic [15:0] hdr_word(input logic [2:0] widx,
                                            input logic [31:0] seq,
                                            input cfg_type cfg);
      logic [15:0] w;
      unique case (widx)
         HW_SYNC_LO: w = SYNC_WORD[15:0];
         HW_SYNC_HI: w = SYNC_WORD[31:16];
         HW_LENGTH:  w = 16'(PAYLOAD_WORDS);
         HW_SEQ_LO:  w = seq[15:0];
         HW_SEQ_HI:  w = seq[31:16];
         HW_MSG_ID:  w = MSG_ID;
         HW_FLAGS:   w = flags_word(cfg);
         default:    w = 16'h0000;
      endcase
      return w;
   endfunction

endpackage

/* hdl/audio_packet_framer_chunker_top.sv */
// ----------------------------------------------------------------------------
// audio_packet_framer_chunker_top
// Frames payload bytes with header and XOR-rotate checksum, in 62-byte chunks.
// ----------------------------------------------------------------------------
// Each payload byte transfer yields one or more output byte transfers, the
// last one flagged by rsp_last_of_run; rsp_frame_end marks the final byte of
// a frame. The output sequencer sends one byte per cycle unless rsp_ready
// stalls it, so an input byte holds it until all its bytes are sent: one
// for most payload bytes, also the header and a chunk mark for the first
// of a frame, also the checksum and any chunk marks for the last. A 4-entry
// queue in front of the sequencer absorbs these bursts. Register values are
// taken when a frame header is sent; write them only while the block is idle.
// ----------------------------------------------------------------------------
module audio_packet_framer_chunker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_link_byte,
   output logic        rsp_frame_end,
   output logic        rsp_last_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   apfc_pkg::cfg_type  cfg_ff, cfg_in;
   apfc_pkg::item_type push_item, q_item;
   logic               push_valid, push_ready;
   logic               q_valid, q_pop;
   logic               csr_write;
   logic [1:0]         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            apfc_pkg::REG_CONTROLLER_INDEX: cfg_in.controller_index = pwdata[0];
            apfc_pkg::REG_TIMESLOT_INDEX:   cfg_in.timeslot_index   = pwdata[0];
            apfc_pkg::REG_DEVICE_CODE:      cfg_in.device_code      = pwdata[7:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         apfc_pkg::REG_CONTROLLER_INDEX: prdata = {31'd0, cfg_ff.controller_index};
         apfc_pkg::REG_TIMESLOT_INDEX:   prdata = {31'd0, cfg_ff.timeslot_index};
         apfc_pkg::REG_DEVICE_CODE:      prdata = {24'd0, cfg_ff.device_code};
         default:                        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   apfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_item        (push_item)
   );

   apfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_item  (q_item)
   );

   apfc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_link_byte   (rsp_link_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The sequencer only pulls from the queue when an entry is there
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // The end of a frame always closes the run of its input byte
   a_frame_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_last_of_run)
      else $error("frame end without last_of_run");

   // A transfer carrying frame end is followed by a fresh chunk mark
   a_fresh_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_frame_end) ##1 rsp_valid
      |-> (rsp_link_byte == apfc_pkg::MARK_LO))
      else $error("frame does not start in a fresh chunk");

endmodule

/* hdl/apfc_queue.sv */
// ----------------------------------------------------------------------------
// apfc_queue
// Short FIFO of classified payload bytes between front and back.
// ----------------------------------------------------------------------------
module apfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  apfc_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output apfc_pkg::item_type out_item
);

   apfc_pkg::item_type           slots_ff [apfc_pkg::QUEUE_DEPTH];
   logic [apfc_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [apfc_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [apfc_pkg::QPTR_W:0]    count_ff, count_in;
   logic                         push, pop;

   assign in_ready  = (count_ff != (apfc_pkg::QPTR_W+1)'(apfc_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* hdl/apfc_front.sv */
// ----------------------------------------------------------------------------
// apfc_front
// Takes payload bytes and tags each with its place in the frame.
// ----------------------------------------------------------------------------
module apfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_payload_byte,
   output logic               push_valid,
   input  logic               push_ready,
   output apfc_pkg::item_type push_item
);

   logic [apfc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       take, is_last;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign take       = req_valid && push_ready;
   assign is_last    = (pos_ff == apfc_pkg::LAST_POS);

   always_comb begin
      push_item.data  = req_payload_byte;
      push_item.first = (pos_ff == '0);
      push_item.last  = is_last;
      push_item.odd   = pos_ff[0];
      pos_in = pos_ff;
      if (take) begin
         pos_in = is_last ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* hdl/apfc_back.sv */
// ----------------------------------------------------------------------------
// apfc_back
// Byte sequencer: header, payload, pad, checksum and chunk marks, one
// output byte per cycle when not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module apfc_back (
   input  logic               clock,
   input  logic               reset,
   input  apfc_pkg::cfg_type  cfg,
   input  logic               q_valid,
   output logic               q_pop,
   input  apfc_pkg::item_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_link_byte,
   output logic               rsp_frame_end,
   output logic               rsp_last_of_run
);

   apfc_pkg::phase_type         phase_ff, phase_in, start_phase;
   apfc_pkg::mark_type          mark_ff, mark_in;
   logic [apfc_pkg::HIDX_W-1:0] hidx_ff, hidx_in;
   logic [apfc_pkg::CP_W-1:0]   cp_ff, cp_in;
   logic [15:0]                 cs_ff, cs_in;
   logic [7:0]                  held_ff, held_in;
   logic [31:0]                 seq_ff, seq_in;
   apfc_pkg::item_type          item_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_end_ff, rsp_end_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        emit, fin, is_frame, need_mark, load;
   logic [7:0]                  out_byte, frame_byte;
   logic [15:0]                 hw;

   assign emit        = (phase_ff != apfc_pkg::PH_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign need_mark   = (cp_ff == '0) && (mark_ff == apfc_pkg::MK_NONE);
   assign hw          = apfc_pkg::hdr_word(hidx_ff[apfc_pkg::HIDX_W-1:1], seq_ff, cfg);
   assign start_phase = q_item.first ? apfc_pkg::PH_HDR : apfc_pkg::PH_PAY;
   assign load        = q_valid && ((phase_ff == apfc_pkg::PH_IDLE) || (emit && fin));
   assign q_pop       = load;

   // Output selection
   always_comb begin
      unique case (phase_ff)
         apfc_pkg::PH_HDR:  frame_byte = hidx_ff[0] ? hw[15:8] : hw[7:0];
         apfc_pkg::PH_PAY:  frame_byte = item_ff.data;
         apfc_pkg::PH_CSLO: frame_byte = cs_ff[7:0];
         apfc_pkg::PH_CSHI: frame_byte = cs_ff[15:8];
         default:           frame_byte = 8'h00;
      endcase
      is_frame = 1'b0;
      fin      = 1'b0;
      priority if (phase_ff == apfc_pkg::PH_TRAIL) begin
         out_byte = (mark_ff == apfc_pkg::MK_NONE) ? apfc_pkg::MARK_LO : apfc_pkg::MARK_HI;
         fin      = (mark_ff == apfc_pkg::MK_LO);
      end else if (need_mark) begin
         out_byte = apfc_pkg::MARK_LO;
      end else if (mark_ff == apfc_pkg::MK_LO) begin
         out_byte = apfc_pkg::MARK_HI;
      end else begin
         out_byte = frame_byte;
         is_frame = 1'b1;
         fin      = ((phase_ff == apfc_pkg::PH_PAY) && !item_ff.last) ||
                    ((phase_ff == apfc_pkg::PH_CSHI) && (cp_ff != apfc_pkg::LAST_CP));
      end
   end

   // Next state
   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      hidx_in  = hidx_ff;
      if (emit && fin) begin
         phase_in = q_valid ? start_phase : apfc_pkg::PH_IDLE;
         mark_in  = apfc_pkg::MK_NONE;
         hidx_in  = '0;
      end else if (emit && !is_frame) begin
         mark_in = (mark_ff == apfc_pkg::MK_NONE) ? apfc_pkg::MK_LO : apfc_pkg::MK_BOTH;
      end else if (emit) begin
         mark_in = apfc_pkg::MK_NONE;
         unique case (phase_ff)
            apfc_pkg::PH_HDR: begin
               hidx_in = hidx_ff + 1'b1;
               if (hidx_ff == apfc_pkg::LAST_HIDX) begin
                  phase_in = apfc_pkg::PH_PAY;
               end
            end
            apfc_pkg::PH_PAY:  phase_in = apfc_pkg::PAYLOAD_ODD ? apfc_pkg::PH_PAD
                                                                : apfc_pkg::PH_CSLO;
            apfc_pkg::PH_PAD:  phase_in = apfc_pkg::PH_CSLO;
            apfc_pkg::PH_CSLO: phase_in = apfc_pkg::PH_CSHI;
            apfc_pkg::PH_CSHI: phase_in = apfc_pkg::PH_TRAIL;
            default:           phase_in = phase_ff;
         endcase
      end else if (phase_ff == apfc_pkg::PH_IDLE && q_valid) begin
         phase_in = start_phase;
      end
   end

   // Frame datapath
   always_comb begin
      cp_in   = cp_ff;
      cs_in   = cs_ff;
      held_in = held_ff;
      seq_in  = seq_ff;
      if (emit && is_frame) begin
         cp_in = ((cp_ff == apfc_pkg::LAST_CP) || (phase_ff == apfc_pkg::PH_CSHI))
                 ? '0 : cp_ff + 1'b1;
         unique case (phase_ff)
            apfc_pkg::PH_HDR: begin
               if (hidx_ff[0]) begin
                  cs_in = apfc_pkg::mix_word(cs_ff, hw);
               end
               if (hidx_ff == apfc_pkg::LAST_HIDX) begin
                  seq_in = seq_ff + 32'd1;
               end
            end
            apfc_pkg::PH_PAY: begin
               if (item_ff.odd) begin
                  cs_in = apfc_pkg::mix_word(cs_ff, {item_ff.data, held_ff});
               end else begin
                  held_in = item_ff.data;
               end
            end
            apfc_pkg::PH_PAD:  cs_in = apfc_pkg::mix_word(cs_ff, {8'h00, held_ff});
            apfc_pkg::PH_CSHI: cs_in = apfc_pkg::CHECK_INIT;
            default:           cs_in = cs_ff;
         endcase
      end
   end

   // Output stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = out_byte;
         rsp_end_in   = fin && item_ff.last;
         rsp_last_in  = fin;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= apfc_pkg::PH_IDLE;
         mark_ff      <= apfc_pkg::MK_NONE;
         hidx_ff      <= '0;
         cp_ff        <= '0;
         cs_ff        <= apfc_pkg::CHECK_INIT;
         held_ff      <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mark_ff      <= mark_in;
         hidx_ff      <= hidx_in;
         cp_ff        <= cp_in;
         cs_ff        <= cs_in;
         held_ff      <= held_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= q_item;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link_byte   = rsp_byte_ff;
   assign rsp_frame_end   = rsp_end_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

/* bench/tb_audio_packet_framer_chunker_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_audio_packet_framer_chunker_top
// Self-checking bench for the chunked audio packet framer.
// ----------------------------------------------------------------------------
// Payload bytes go in over valid/ready. A local framer builds the expected
// chunked byte stream (header, sequence number, flags, payload, checksum and
// chunk marks) for every accepted byte. The monitor compares each output
// transfer in order. The register port is exercised with extreme, masked and
// unmapped writes and is read back. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_audio_packet_framer_chunker_top;

   localparam int         LIMIT_CYCLES = 100000;
   localparam int         DRAIN_CYCLES = 32;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [7:0] link_byte;
      logic       frame_end;
      logic       last_of_run;
   } link_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_payload_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_link_byte;
   logic        rsp_frame_end;
   logic        rsp_last_of_run;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'h0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // framer shadow state
   apfc_pkg::cfg_type register_shadow = '0;
   logic [31:0]       frame_seq = 32'h0;
   logic [15:0]       frame_sum = apfc_pkg::CHECK_INIT;
   int                payload_fill = 0;
   logic [7:0]        low_byte_held = 8'h00;
   int                chunk_fill = 0;
   link_beat_type     link_bytes_due [$];

   int mismatch_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   audio_packet_framer_chunker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_link_byte    (rsp_link_byte),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_last_of_run  (rsp_last_of_run),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   function automatic logic [15:0] xor_rotl(input logic [15:0] acc, input logic [15:0] w);
      logic [15:0] t;
      t = acc ^ w;
      return (t << 1) | (t >> 15);
   endfunction

   function automatic void append_beat(input link_beat_type beat);
      link_bytes_due.insert(link_bytes_due.size(), beat);
   endfunction

   function automatic void push_link_byte(input logic [7:0] b);
      link_beat_type beat;
      beat.link_byte   = b;
      beat.frame_end   = 1'b0;
      beat.last_of_run = 1'b0;
      append_beat(beat);
   endfunction

   // every frame byte lands in a chunk; a fresh chunk opens with its mark
   function automatic void push_frame_byte(input logic [7:0] b);
      if (chunk_fill == 0) begin
         push_link_byte(apfc_pkg::MARK_LO);
         push_link_byte(apfc_pkg::MARK_HI);
      end
      push_link_byte(b);
      chunk_fill++;
      if (chunk_fill >= apfc_pkg::CHUNK_BYTES) chunk_fill = 0;
   endfunction

   function automatic void frame_payload_byte(input logic [7:0] b);
      logic [15:0]   hdr [7];
      link_beat_type tail;
      if (payload_fill == 0) begin
         hdr[0] = apfc_pkg::SYNC_WORD[15:0];
         hdr[1] = apfc_pkg::SYNC_WORD[31:16];
         hdr[2] = 16'((apfc_pkg::PAYLOAD_BYTES + 1) / 2);
         hdr[3] = frame_seq[15:0];
         hdr[4] = frame_seq[31:16];
         hdr[5] = apfc_pkg::MSG_ID;
         hdr[6] = {apfc_pkg::PROTO_BITS, register_shadow.controller_index,
                   register_shadow.timeslot_index, register_shadow.device_code[3:0], 8'h00}
                  | {8'h00, register_shadow.device_code};
         frame_seq  = frame_seq + 32'd1;
         frame_sum  = apfc_pkg::CHECK_INIT;
         chunk_fill = 0;
         foreach (hdr[k]) begin
            frame_sum = xor_rotl(frame_sum, hdr[k]);
            push_frame_byte(hdr[k][7:0]);
            push_frame_byte(hdr[k][15:8]);
         end
      end
      push_frame_byte(b);
      if (payload_fill % 2 == 0) low_byte_held = b;
      else frame_sum = xor_rotl(frame_sum, {b, low_byte_held});
      payload_fill++;
      if (payload_fill >= apfc_pkg::PAYLOAD_BYTES) begin
         // odd payload: zero pad completes the last word
         if (payload_fill % 2 == 1) begin
            frame_sum = xor_rotl(frame_sum, {8'h00, low_byte_held});
            push_frame_byte(8'h00);
         end
         push_frame_byte(frame_sum[7:0]);
         push_frame_byte(frame_sum[15:8]);
         // frame filled its last chunk exactly: empty trailing mark
         if (chunk_fill == 0) begin
            push_link_byte(apfc_pkg::MARK_LO);
            push_link_byte(apfc_pkg::MARK_HI);
         end
         tail = link_bytes_due.pop_back();
         tail.frame_end = 1'b1;
         append_beat(tail);
         chunk_fill   = 0;
         payload_fill = 0;
         frame_sum    = apfc_pkg::CHECK_INIT;
      end
      tail = link_bytes_due.pop_back();
      tail.last_of_run = 1'b1;
      append_beat(tail);
   endfunction

   // prediction and checking share one process, so a same-edge pass-through
   // is predicted before it is compared
   always @(posedge clock) begin
      link_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) frame_payload_byte(req_payload_byte);
         if (rsp_valid && rsp_ready) begin
            if (link_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer, byte %h", rsp_link_byte));
            end else begin
               want = link_bytes_due.pop_front();
               if (rsp_link_byte !== want.link_byte)
                  report_mismatch($sformatf("link_byte %h, want %h",
                                            rsp_link_byte, want.link_byte));
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch($sformatf("frame_end %b, want %b",
                                            rsp_frame_end, want.frame_end));
               if (rsp_last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %b, want %b",
                                            rsp_last_of_run, want.last_of_run));
            end
         end
      end
   end

   task automatic send_payload_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_payload_byte <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (link_bytes_due.size() != 0);
   endtask

   task automatic apb_transfer(input logic wr, input logic [1:0] idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (wr) begin
         case (idx)
            apfc_pkg::REG_CONTROLLER_INDEX: register_shadow.controller_index = wdata[0];
            apfc_pkg::REG_TIMESLOT_INDEX:   register_shadow.timeslot_index   = wdata[0];
            apfc_pkg::REG_DEVICE_CODE:      register_shadow.device_code      = wdata[7:0];
            default: ;
         endcase
      end
      @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] unused;
      apb_transfer(1'b1, idx, value, unused);
   endtask

   task automatic check_registers();
      logic [31:0] got;
      apb_transfer(1'b0, apfc_pkg::REG_CONTROLLER_INDEX, 32'h0, got);
      if (got !== {31'b0, register_shadow.controller_index})
         report_mismatch($sformatf("controller_index reads %h", got));
      apb_transfer(1'b0, apfc_pkg::REG_TIMESLOT_INDEX, 32'h0, got);
      if (got !== {31'b0, register_shadow.timeslot_index})
         report_mismatch($sformatf("timeslot_index reads %h", got));
      apb_transfer(1'b0, apfc_pkg::REG_DEVICE_CODE, 32'h0, got);
      if (got !== {24'b0, register_shadow.device_code})
         report_mismatch($sformatf("device_code reads %h", got));
   endtask

   task automatic test_register_reset_values();
      check_registers();
   endtask

   // opening of the first frame: header burst, then byte extremes and
   // walking bits
   task automatic test_frame_start_directed();
      logic [7:0] pattern [24] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
                                   8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'hFD, 8'hFB,
                                   8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h00, 8'h00, 8'hFF, 8'hFF};
      req_idle_pct = 28;
      rsp_idle_pct = 46;
      foreach (pattern[k]) send_payload_byte(pattern[k]);
      wait_for_drain();
   endtask

   task automatic test_register_extremes();
      write_register(apfc_pkg::REG_CONTROLLER_INDEX, 32'h1);
      write_register(apfc_pkg::REG_TIMESLOT_INDEX, 32'h1);
      write_register(apfc_pkg::REG_DEVICE_CODE, 32'hFF);
      // no register behind this index; nothing may change
      write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
      check_registers();
   endtask

   task automatic test_register_masking();
      write_register(apfc_pkg::REG_CONTROLLER_INDEX, 32'h8000_0001);
      write_register(apfc_pkg::REG_TIMESLOT_INDEX, 32'hFFFF_FFFE);
      write_register(apfc_pkg::REG_DEVICE_CODE,
                     {24'($urandom_range(32'hFF_FFFF, 1)), 8'($urandom)});
      check_registers();
   endtask

   task automatic test_payload_stream(input int count, input int req_pct, input int rsp_pct);
      logic [7:0] b;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      repeat (count) begin
         case ($urandom_range(7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom);
         endcase
         send_payload_byte(b);
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset_values();
      // first frame carries the extreme flags
      test_register_extremes();
      test_frame_start_directed();
      // ends exactly on a frame boundary
      test_payload_stream(apfc_pkg::PAYLOAD_BYTES - 24, 46, 28);
      // next frame opens with the masked flags
      test_register_masking();
      test_payload_stream(10, 0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && link_bytes_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
